@@ rtl/prpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prpe_pkg;

  localparam int SQ_N = 49;
  localparam int SQ_W = 2 * SQ_N;

  localparam int NUM_W = 49;
  localparam int HM_W = 33;
  localparam int FRAC = 15;
  localparam int Q_W = 16;
  localparam int DIV_STEPS = 16;
  localparam int DIV_LAT = DIV_STEPS + 1;

  localparam int DR_W = 33;
  localparam int DIST_W = 27;
  localparam int D25_K = 38;
  localparam logic [33:0] D25_M = 34'(((64'd1 << D25_K) + 64'd24) / 64'd25);

  localparam int FRONT = 6;
  localparam int BACK = SQ_N + DIV_LAT;

  localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7fff;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 16'h8000;

  typedef struct packed {
    logic [HM_W-1:0] hd;
    logic [HM_W-1:0] hc;
    logic [NUM_W-1:0] bd;
    logic [NUM_W-1:0] bc;
  } num_t;

  typedef struct packed {
    logic ok;
    logic neg_hd;
    logic neg_hc;
    logic neg_bd;
    logic neg_bc;
  } side_t;

  function automatic logic [Q_W-1:0] q15_sat(input logic [Q_W-1:0] q, input logic neg);
    logic [Q_W-1:0] r;
    if (neg) begin
      r = (q > Q_NEG_MAX) ? Q_NEG_MAX : (~q + 1'b1);
    end else begin
      r = (q > Q_POS_MAX) ? Q_POS_MAX : q;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pairwise_relative_pose_encoder.sv @@
// Relative pose encoder for one node pair per request: heading cosine and sine between
// the two directions, bearing cosine and sine between the target direction and the
// centre offset, and the offset length over 50. A new request is taken every cycle while
// in_stall is low; a result passes through six arithmetic stages, the 49-stage square
// root on the 98-bit bearing product, the 17-stage quotient unit and the output register.
// in_stall rises only once the output register and its skid entry are both full.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_relative_pose_encoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] source_x,
  input  wire logic signed [31:0] source_y,
  input  wire logic signed [15:0] source_dir_x,
  input  wire logic signed [15:0] source_dir_y,
  input  wire logic               source_ok,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [15:0] target_dir_x,
  input  wire logic signed [15:0] target_dir_y,
  input  wire logic               target_ok,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    pair_ok,
  output logic signed [15:0]      cos_heading,
  output logic signed [15:0]      sin_heading,
  output logic signed [15:0]      cos_bearing,
  output logic signed [15:0]      sin_bearing,
  output logic        [26:0]      scaled_distance
);

  localparam int SW = prpe_pkg::SQ_W;
  localparam int SN = prpe_pkg::SQ_N;
  localparam int NW = prpe_pkg::NUM_W;
  localparam int QW = prpe_pkg::Q_W;
  localparam int FR = prpe_pkg::FRONT;
  localparam int BK = prpe_pkg::BACK;

  logic en;
  logic fv [1:FR];
  logic fo [1:FR];

  logic signed [31:0] a_ss0, a_ss1, a_tt0, a_tt1, a_d0, a_d1, a_c0, a_c1;
  logic signed [32:0] a_dx, a_dy;
  logic signed [15:0] a_tdx, a_tdy;

  logic        [31:0] b_ls, b_lt;
  logic signed [32:0] b_hd, b_hc, b_dx, b_dy;
  logic        [32:0] b_adx, b_ady;
  logic signed [15:0] b_tdx, b_tdy;

  logic        [63:0] c_hp;
  logic        [65:0] c_ox, c_oy;
  logic signed [48:0] c_b0, c_b1, c_b2, c_b3;
  logic        [31:0] c_lt;
  logic signed [32:0] c_hd, c_hc;

  logic        [65:0] d_off;
  logic signed [49:0] d_bd, d_bc;
  logic        [63:0] d_hp;
  logic        [31:0] d_lt;
  logic signed [32:0] d_hd, d_hc;

  logic [63:0] e_plo, e_hp;
  logic [65:0] e_phi, e_off;
  prpe_pkg::num_t  e_num;
  prpe_pkg::side_t e_side;

  logic [SW-1:0] f_hp, f_bp, f_off;
  prpe_pkg::num_t  f_num;
  prpe_pkg::side_t f_side;

  prpe_pkg::num_t  nd [1:SN];
  prpe_pkg::side_t sp [1:BK];
  logic            vl [1:BK];

  logic [SN-1:0] root_h, root_b, root_d;
  logic [QW-1:0] q_ch, q_sh, q_cb, q_sb;
  logic [26:0]   span;

  logic               p_ok;
  logic signed [15:0] p_ch, p_sh, p_cb, p_sb;
  logic        [26:0] p_dist;

  logic               sk_v;
  logic               sk_ok;
  logic signed [15:0] sk_ch, sk_sh, sk_cb, sk_sb;
  logic        [26:0] sk_dist;

  assign en       = !sk_v;
  assign in_stall = sk_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= FR; i++) begin
        fv[i] <= 1'b0;
      end
    end else if (en) begin
      fv[1] <= in_valid;
      for (int i = 2; i <= FR; i++) begin
        fv[i] <= fv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo[1] <= source_ok & target_ok;
      for (int i = 2; i <= FR; i++) begin
        fo[i] <= fo[i-1];
      end

      // products of the direction components and centre offset
      a_ss0 <= 32'(source_dir_x) * 32'(source_dir_x);
      a_ss1 <= 32'(source_dir_y) * 32'(source_dir_y);
      a_tt0 <= 32'(target_dir_x) * 32'(target_dir_x);
      a_tt1 <= 32'(target_dir_y) * 32'(target_dir_y);
      a_d0  <= 32'(target_dir_x) * 32'(source_dir_x);
      a_d1  <= 32'(target_dir_y) * 32'(source_dir_y);
      a_c0  <= 32'(target_dir_x) * 32'(source_dir_y);
      a_c1  <= 32'(target_dir_y) * 32'(source_dir_x);
      a_dx  <= 33'(target_x) - 33'(source_x);
      a_dy  <= 33'(target_y) - 33'(source_y);
      a_tdx <= target_dir_x;
      a_tdy <= target_dir_y;

      b_ls  <= a_ss0 + a_ss1;
      b_lt  <= a_tt0 + a_tt1;
      b_hd  <= 33'(a_d0) + 33'(a_d1);
      b_hc  <= 33'(a_c0) - 33'(a_c1);
      b_adx <= a_dx[32] ? (~$unsigned(a_dx) + 33'd1) : $unsigned(a_dx);
      b_ady <= a_dy[32] ? (~$unsigned(a_dy) + 33'd1) : $unsigned(a_dy);
      b_dx  <= a_dx;
      b_dy  <= a_dy;
      b_tdx <= a_tdx;
      b_tdy <= a_tdy;

      c_hp <= 64'(b_ls) * 64'(b_lt);
      c_ox <= 66'(b_adx) * 66'(b_adx);
      c_oy <= 66'(b_ady) * 66'(b_ady);
      c_b0 <= 49'(b_tdx) * 49'(b_dx);
      c_b1 <= 49'(b_tdy) * 49'(b_dy);
      c_b2 <= 49'(b_tdx) * 49'(b_dy);
      c_b3 <= 49'(b_tdy) * 49'(b_dx);
      c_lt <= b_lt;
      c_hd <= b_hd;
      c_hc <= b_hc;

      d_off <= c_ox + c_oy;
      d_bd  <= 50'(c_b0) + 50'(c_b1);
      d_bc  <= 50'(c_b2) - 50'(c_b3);
      d_hp  <= c_hp;
      d_lt  <= c_lt;
      d_hd  <= c_hd;
      d_hc  <= c_hc;

      // split product: target length squared times offset length squared
      e_plo         <= 64'(d_lt) * 64'(d_off[31:0]);
      e_phi         <= 66'(d_lt) * 66'(d_off[65:32]);
      e_off         <= d_off;
      e_hp          <= d_hp;
      e_num.hd      <= d_hd[32] ? (~$unsigned(d_hd) + 33'd1) : $unsigned(d_hd);
      e_num.hc      <= d_hc[32] ? (~$unsigned(d_hc) + 33'd1) : $unsigned(d_hc);
      e_num.bd      <= d_bd[49] ? NW'(~$unsigned(d_bd) + 50'd1) : NW'($unsigned(d_bd));
      e_num.bc      <= d_bc[49] ? NW'(~$unsigned(d_bc) + 50'd1) : NW'($unsigned(d_bc));
      e_side.ok     <= fo[4];
      e_side.neg_hd <= d_hd[32];
      e_side.neg_hc <= d_hc[32];
      e_side.neg_bd <= d_bd[49];
      e_side.neg_bc <= d_bc[49];

      f_bp   <= {e_phi, 32'b0} + SW'(e_plo);
      f_hp   <= SW'(e_hp);
      f_off  <= SW'(e_off);
      f_num  <= e_num;
      f_side <= e_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= BK; i++) begin
        vl[i] <= 1'b0;
      end
    end else if (en) begin
      vl[1] <= fv[FR];
      for (int i = 2; i <= BK; i++) begin
        vl[i] <= vl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nd[1] <= f_num;
      for (int i = 2; i <= SN; i++) begin
        nd[i] <= nd[i-1];
      end
      sp[1] <= f_side;
      for (int i = 2; i <= BK; i++) begin
        sp[i] <= sp[i-1];
      end
    end
  end

  prpe_isqrt u_sqrt_h (.clk(clk), .en(en), .x(f_hp),  .root(root_h));
  prpe_isqrt u_sqrt_b (.clk(clk), .en(en), .x(f_bp),  .root(root_b));
  prpe_isqrt u_sqrt_d (.clk(clk), .en(en), .x(f_off), .root(root_d));

  prpe_div u_div_ch (.clk(clk), .en(en), .mag(NW'(nd[SN].hd)), .den(root_h), .quo(q_ch));
  prpe_div u_div_sh (.clk(clk), .en(en), .mag(NW'(nd[SN].hc)), .den(root_h), .quo(q_sh));
  prpe_div u_div_cb (.clk(clk), .en(en), .mag(nd[SN].bd),      .den(root_b), .quo(q_cb));
  prpe_div u_div_sb (.clk(clk), .en(en), .mag(nd[SN].bc),      .den(root_b), .quo(q_sb));

  prpe_dist u_dist (.clk(clk), .en(en), .root(root_d), .scaled(span));

  // invalid pair gives all zero
  always_comb begin
    p_ok   = sp[BK].ok;
    p_ch   = p_ok ? prpe_pkg::q15_sat(q_ch, sp[BK].neg_hd) : '0;
    p_sh   = p_ok ? prpe_pkg::q15_sat(q_sh, sp[BK].neg_hc) : '0;
    p_cb   = p_ok ? prpe_pkg::q15_sat(q_cb, sp[BK].neg_bd) : '0;
    p_sb   = p_ok ? prpe_pkg::q15_sat(q_sb, sp[BK].neg_bc) : '0;
    p_dist = p_ok ? span : '0;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (sk_v) begin
        out_valid <= 1'b1;
        sk_v      <= 1'b0;
      end else begin
        out_valid <= vl[BK];
      end
    end else if (vl[BK]) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (sk_v) begin
        pair_ok         <= sk_ok;
        cos_heading     <= sk_ch;
        sin_heading     <= sk_sh;
        cos_bearing     <= sk_cb;
        sin_bearing     <= sk_sb;
        scaled_distance <= sk_dist;
      end else begin
        pair_ok         <= p_ok;
        cos_heading     <= p_ch;
        sin_heading     <= p_sh;
        cos_bearing     <= p_cb;
        sin_bearing     <= p_sb;
        scaled_distance <= p_dist;
      end
    end else if (en) begin
      sk_ok   <= p_ok;
      sk_ch   <= p_ch;
      sk_sh   <= p_sh;
      sk_cb   <= p_cb;
      sk_sb   <= p_sb;
      sk_dist <= p_dist;
    end
  end

endmodule

`default_nettype wire

@@ rtl/prpe_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prpe_isqrt (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [prpe_pkg::SQ_W-1:0] x,
  output logic      [prpe_pkg::SQ_N-1:0] root
);

  localparam int W = prpe_pkg::SQ_W;
  localparam int N = prpe_pkg::SQ_N;

  logic [W-1:0] op_q  [1:N-1];
  logic [W-1:0] res_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] ONE = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0] op_i;
    logic [W-1:0] res_i;
    logic [W-1:0] trial;

    if (k == 0) begin : g_first
      assign op_i  = x;
      assign res_i = '0;
    end else begin : g_rest
      assign op_i  = op_q[k];
      assign res_i = res_q[k];
    end

    assign trial = res_i + ONE;

    if (k < N - 1) begin : g_op
      always_ff @(posedge clk) begin
        if (en) begin
          op_q[k+1] <= (op_i >= trial) ? op_i - trial : op_i;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_q[k+1] <= (op_i >= trial) ? (res_i >> 1) + ONE : res_i >> 1;
      end
    end
  end

  assign root = res_q[N][N-1:0];

endmodule

`default_nettype wire

@@ rtl/prpe_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prpe_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [prpe_pkg::NUM_W-1:0] mag,
  input  wire logic [prpe_pkg::NUM_W-1:0] den,
  output logic      [prpe_pkg::Q_W-1:0]   quo
);

  localparam int NW = prpe_pkg::NUM_W;
  localparam int FR = prpe_pkg::FRAC;
  localparam int S = prpe_pkg::DIV_STEPS;
  localparam int QW = prpe_pkg::Q_W;
  localparam int DV_W = NW + FR + 1;

  logic [NW-1:0]   den_c;
  logic [DV_W-1:0] rem_q [0:S-1];
  logic [NW-1:0]   d_q   [0:S-1];
  logic [QW-1:0]   q_q   [1:S];

  // zero length clamps to one lsb
  assign den_c = (den == '0) ? NW'(1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= {1'b0, mag, {FR{1'b0}}} + DV_W'(den_c >> 1);
      d_q[0]   <= den_c;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_step
    localparam int SH = S - 1 - k;
    logic [DV_W-1:0] shifted;
    logic [QW-1:0]   q_i;
    logic            ge;

    if (k == 0) begin : g_first
      assign q_i = '0;
    end else begin : g_rest
      assign q_i = q_q[k];
    end

    assign shifted = DV_W'(d_q[k]) << SH;
    assign ge      = (rem_q[k] >= shifted);

    if (k < S - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1] <= ge ? rem_q[k] - shifted : rem_q[k];
          d_q[k+1]   <= d_q[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[k+1] <= {q_i[QW-2:0], ge};
      end
    end
  end

  assign quo = q_q[S];

endmodule

`default_nettype wire

@@ rtl/prpe_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prpe_dist (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [prpe_pkg::SQ_N-1:0]   root,
  output logic      [prpe_pkg::DIST_W-1:0] scaled
);

  localparam int DR = prpe_pkg::DR_W;
  localparam int DW = prpe_pkg::DIST_W;
  localparam int K = prpe_pkg::D25_K;
  localparam int DL = prpe_pkg::DIV_LAT - 2;
  localparam logic [16:0] MH = prpe_pkg::D25_M[33:17];
  localparam logic [16:0] ML = prpe_pkg::D25_M[16:0];

  logic [DR:0]    sum_r;
  logic [DR-1:0]  half;
  logic [DR+16:0] pa;
  logic [DR+16:0] pb;
  logic [DR+33:0] prod;
  logic [DW-1:0]  dl [0:DL-1];

  // round half up, then halve so the divide is by 25
  assign sum_r = (DR+1)'(root[DR-1:0]) + (DR+1)'(25);
  assign prod  = {pa, 17'b0} + (DR+34)'(pb);

  always_ff @(posedge clk) begin
    if (en) begin
      half  <= sum_r[DR:1];
      pa    <= (DR+17)'(half) * (DR+17)'(MH);
      pb    <= (DR+17)'(half) * (DR+17)'(ML);
      dl[0] <= prod[K+DW-1:K];
      for (int i = 1; i < DL; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  assign scaled = dl[DL-1];

endmodule

`default_nettype wire
